/* sv/ccts_pkg.sv */
// Shared types and constants for the charge/communication time-slot sequencer.
// No dependencies.
package ccts_pkg;

  localparam int TX_DEPTH = 128;
  localparam int TX_AW    = $clog2(TX_DEPTH);
  localparam int TX_CW    = $clog2(TX_DEPTH + 1);
  localparam int RX_DEPTH = 1024;
  localparam int RX_AW    = $clog2(RX_DEPTH);
  localparam int RX_CW    = $clog2(RX_DEPTH + 1);

  localparam int TIME_W   = 16;
  localparam int CFG_IW   = 3;
  localparam int NUM_CFG  = 7;

  typedef logic [1:0]        op_t;
  typedef logic [2:0]        mode_t;
  typedef logic [7:0]        byte_t;
  typedef logic [TIME_W-1:0] time_t;
  typedef logic [CFG_IW-1:0] cfg_idx_t;

  localparam op_t OP_TICK = 2'd0;
  localparam op_t OP_HOST = 2'd1;
  localparam op_t OP_LINK = 2'd2;
  localparam op_t OP_IDLE = 2'd3;

  localparam mode_t M_CHG     = 3'd0;
  localparam mode_t M_PRE_RX  = 3'd1;
  localparam mode_t M_RX      = 3'd2;
  localparam mode_t M_PRE_TX  = 3'd3;
  localparam mode_t M_TX      = 3'd4;
  localparam mode_t M_POST_TX = 3'd5;
  localparam mode_t M_RST     = 3'd6;

  localparam cfg_idx_t CFG_CHARGE_TIME   = 3'd0;
  localparam cfg_idx_t CFG_SYNC_TIMEOUT  = 3'd1;
  localparam cfg_idx_t CFG_RECEIVE_TIME  = 3'd2;
  localparam cfg_idx_t CFG_RX_TO_TX      = 3'd3;
  localparam cfg_idx_t CFG_TRANSMIT_TIME = 3'd4;
  localparam cfg_idx_t CFG_TX_TO_CHARGE  = 3'd5;
  localparam cfg_idx_t CFG_RST_TO_CHARGE = 3'd6;

  localparam time_t CFG_RESET [NUM_CFG] = '{
    16'd300, 16'd250, 16'd245, 16'd1, 16'd90, 16'd30, 16'd100
  };

  // one item on its way from the input transfer to the result register
  typedef struct packed {
    mode_t mode;
    logic  led;
    logic  link_v;
    logic  link_byp;
    byte_t link_byp_byte;
    logic  host_v;
    time_t sync;
  } stage_t;

endpackage

/* sv/ccts_if.sv */
// Channel interfaces: item input, result output and configuration write.
// Depends on ccts_pkg.
interface ccts_in_if;
  logic               valid;
  logic               ready;
  ccts_pkg::op_t      op;
  ccts_pkg::byte_t    data_byte;
  logic               line_low;
  modport source (output valid, op, data_byte, line_low, input ready);
  modport sink   (input valid, op, data_byte, line_low, output ready);
endinterface

interface ccts_out_if;
  logic               valid;
  logic               ready;
  ccts_pkg::mode_t    mode;
  logic               relay_tx;
  logic               relay_rx;
  logic               relay_charge;
  logic               link_enabled;
  logic               charge_led;
  logic               link_out_valid;
  ccts_pkg::byte_t    link_out_byte;
  logic               host_out_valid;
  ccts_pkg::byte_t    host_out_byte;
  ccts_pkg::time_t    sync_time;
  modport source (output valid, mode, relay_tx, relay_rx, relay_charge, link_enabled,
                  charge_led, link_out_valid, link_out_byte, host_out_valid,
                  host_out_byte, sync_time, input ready);
  modport sink   (input valid, mode, relay_tx, relay_rx, relay_charge, link_enabled,
                  charge_led, link_out_valid, link_out_byte, host_out_valid,
                  host_out_byte, sync_time, output ready);
endinterface

interface ccts_cfg_if;
  logic               valid;
  logic               ready;
  ccts_pkg::cfg_idx_t index;
  ccts_pkg::time_t    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/ccts_ram.sv */
// Generic single-write, single-read byte RAM with registered read data.
// No dependencies.
module ccts_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/charge_comm_time_slot_sequencer_top.sv */
// Time-slot sequencer: mode timing, transmit and receive byte FIFOs, result pipeline.
// A result is registered in the stage register with the FIFO read, then in the result
// register. Throughput: one item per cycle while out_ch.ready is high.
// Reset (rst_n low, synchronous): charge mode, counters zero, both FIFOs empty,
// registers at their defaults; FIFO storage is not cleared.
// Depends on ccts_pkg, ccts_if and ccts_ram.
module charge_comm_time_slot_sequencer_top (
  input logic        clk,
  input logic        rst_n,
  ccts_in_if.sink    in_ch,
  ccts_out_if.source out_ch,
  ccts_cfg_if.sink   cfg_ch
);
  import ccts_pkg::*;

  time_t              cfg_r [NUM_CFG];
  mode_t              mode_r, mode_nxt;
  time_t              elapsed_r, elapsed_nxt, elapsed_inc;
  time_t              sync_r, sync_nxt;
  logic [TX_AW-1:0]   tx_head_r, tx_head_nxt;
  logic [TX_CW-1:0]   tx_count_r, tx_count_nxt, tx_cnt1;
  logic [RX_AW-1:0]   rx_head_r, rx_head_nxt;
  logic [RX_CW-1:0]   rx_count_r, rx_count_nxt;
  logic               pend_r, pend_nxt;
  logic               seen_r, seen_nxt;
  logic               led_r, led_nxt;

  logic               accept;
  logic               tx_push, tx_pop, rx_push, rx_pop, change;
  logic [TX_CW:0]     tx_wsum;
  logic [TX_AW-1:0]   tx_waddr;
  logic [RX_CW:0]     rx_wsum;
  logic [RX_AW-1:0]   rx_waddr;
  logic [TIME_W:0]    rx_span;
  byte_t              tx_rdata, rx_rdata;

  stage_t             st_nxt, st_r;
  logic               st_v_r, st_adv;
  logic               out_v_r;
  byte_t              link_b, host_b;

  assign cfg_ch.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CFG; i++) begin
        cfg_r[i] <= CFG_RESET[i];
      end
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_CHARGE_TIME:   cfg_r[CFG_CHARGE_TIME]   <= cfg_ch.data;
        CFG_SYNC_TIMEOUT:  cfg_r[CFG_SYNC_TIMEOUT]  <= cfg_ch.data;
        CFG_RECEIVE_TIME:  cfg_r[CFG_RECEIVE_TIME]  <= cfg_ch.data;
        CFG_RX_TO_TX:      cfg_r[CFG_RX_TO_TX]      <= cfg_ch.data;
        CFG_TRANSMIT_TIME: cfg_r[CFG_TRANSMIT_TIME] <= cfg_ch.data;
        CFG_TX_TO_CHARGE:  cfg_r[CFG_TX_TO_CHARGE]  <= cfg_ch.data;
        CFG_RST_TO_CHARGE: cfg_r[CFG_RST_TO_CHARGE] <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign st_adv      = st_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = rst_n && (!st_v_r || st_adv);
  assign accept      = in_ch.valid && in_ch.ready;

  assign elapsed_inc = (in_ch.op == OP_TICK && elapsed_r != '1) ?
                       elapsed_r + 1'b1 : elapsed_r;
  assign tx_push = (in_ch.op == OP_HOST) && (tx_count_r < TX_CW'(TX_DEPTH));
  assign tx_cnt1 = tx_count_r + TX_CW'(tx_push);
  assign rx_span = {1'b0, elapsed_inc} + {1'b0, sync_r};

  assign tx_wsum  = {1'b0, TX_CW'(tx_head_r)} + {1'b0, tx_count_r};
  assign tx_waddr = (tx_wsum >= (TX_CW + 1)'(TX_DEPTH)) ?
                    TX_AW'(tx_wsum - (TX_CW + 1)'(TX_DEPTH)) : TX_AW'(tx_wsum);
  assign rx_wsum  = {1'b0, RX_CW'(rx_head_r)} + {1'b0, rx_count_r};
  assign rx_waddr = (rx_wsum >= (RX_CW + 1)'(RX_DEPTH)) ?
                    RX_AW'(rx_wsum - (RX_CW + 1)'(RX_DEPTH)) : RX_AW'(rx_wsum);

  always_comb begin
    mode_nxt = mode_r;
    sync_nxt = sync_r;
    pend_nxt = pend_r;
    seen_nxt = seen_r;
    led_nxt  = led_r;
    change   = 1'b0;
    tx_pop   = 1'b0;
    rx_pop   = 1'b0;
    rx_push  = 1'b0;
    case (mode_r)
      M_CHG: begin
        if (elapsed_inc > cfg_r[CFG_CHARGE_TIME]) begin
          mode_nxt = M_PRE_RX;
          change   = 1'b1;
        end else if (seen_r && rx_count_r != '0) begin
          rx_pop = 1'b1;
        end
      end
      M_PRE_RX: begin
        sync_nxt = elapsed_inc;
        if (elapsed_inc > cfg_r[CFG_SYNC_TIMEOUT]) begin
          mode_nxt = M_RST;
          change   = 1'b1;
        end else if (in_ch.op == OP_TICK && in_ch.line_low) begin
          mode_nxt = M_RX;
          change   = 1'b1;
        end
      end
      M_RX: begin
        if (rx_span > {1'b0, cfg_r[CFG_RECEIVE_TIME]}) begin
          mode_nxt = M_PRE_TX;
          change   = 1'b1;
        end else if (in_ch.op == OP_LINK) begin
          led_nxt = 1'b1;
          if (rx_count_r < RX_CW'(RX_DEPTH)) begin
            rx_push  = 1'b1;
            seen_nxt = 1'b1;
          end
        end
      end
      M_PRE_TX: begin
        if (elapsed_inc > cfg_r[CFG_RX_TO_TX]) begin
          mode_nxt = M_TX;
          change   = 1'b1;
          pend_nxt = 1'b1;
        end
      end
      M_TX: begin
        if (elapsed_inc > cfg_r[CFG_TRANSMIT_TIME]) begin
          mode_nxt = M_POST_TX;
          change   = 1'b1;
        end else if (pend_r) begin
          tx_pop = (tx_cnt1 != '0);
          if (tx_cnt1 - TX_CW'(tx_pop) == '0) begin
            pend_nxt = 1'b0;
          end
        end
      end
      M_POST_TX: begin
        if (elapsed_inc > cfg_r[CFG_TX_TO_CHARGE]) begin
          mode_nxt = M_CHG;
          change   = 1'b1;
        end
      end
      M_RST: begin
        if (elapsed_inc > cfg_r[CFG_RST_TO_CHARGE]) begin
          mode_nxt = M_CHG;
          change   = 1'b1;
        end
      end
      default: ;
    endcase
    elapsed_nxt  = change ? '0 : elapsed_inc;
    tx_count_nxt = tx_cnt1 - TX_CW'(tx_pop);
    tx_head_nxt  = tx_pop ? ((tx_head_r == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head_r + 1'b1)
                          : tx_head_r;
    rx_count_nxt = rx_count_r + RX_CW'(rx_push) - RX_CW'(rx_pop);
    rx_head_nxt  = rx_pop ? ((rx_head_r == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head_r + 1'b1)
                          : rx_head_r;

    st_nxt.mode          = mode_nxt;
    st_nxt.led           = led_nxt;
    st_nxt.link_v        = tx_pop;
    st_nxt.link_byp      = (tx_count_r == '0);
    st_nxt.link_byp_byte = in_ch.data_byte;
    st_nxt.host_v        = rx_pop;
    st_nxt.sync          = sync_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_CHG;
      elapsed_r  <= '0;
      sync_r     <= '0;
      tx_head_r  <= '0;
      tx_count_r <= '0;
      rx_head_r  <= '0;
      rx_count_r <= '0;
      pend_r     <= 1'b0;
      seen_r     <= 1'b0;
      led_r      <= 1'b0;
    end else if (accept) begin
      mode_r     <= mode_nxt;
      elapsed_r  <= elapsed_nxt;
      sync_r     <= sync_nxt;
      tx_head_r  <= tx_head_nxt;
      tx_count_r <= tx_count_nxt;
      rx_head_r  <= rx_head_nxt;
      rx_count_r <= rx_count_nxt;
      pend_r     <= pend_nxt;
      seen_r     <= seen_nxt;
      led_r      <= led_nxt;
    end
  end

  ccts_ram #(.DEPTH(TX_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (accept && tx_push),
    .waddr (tx_waddr),
    .wdata (in_ch.data_byte),
    .re    (accept),
    .raddr (tx_head_r),
    .rdata (tx_rdata)
  );

  ccts_ram #(.DEPTH(RX_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (accept && rx_push),
    .waddr (rx_waddr),
    .wdata (in_ch.data_byte),
    .re    (accept),
    .raddr (rx_head_r),
    .rdata (rx_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r <= 1'b0;
    end else if (accept) begin
      st_v_r <= 1'b1;
    end else if (st_adv) begin
      st_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_r <= st_nxt;
    end
  end

  assign link_b = !st_r.link_v ? '0 : (st_r.link_byp ? st_r.link_byp_byte : tx_rdata);
  assign host_b = st_r.host_v ? rx_rdata : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (st_adv) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_adv) begin
      out_ch.mode           <= st_r.mode;
      out_ch.relay_tx       <= (st_r.mode == M_PRE_TX) || (st_r.mode == M_TX);
      out_ch.relay_rx       <= (st_r.mode == M_PRE_RX) || (st_r.mode == M_RX);
      out_ch.relay_charge   <= (st_r.mode == M_CHG);
      out_ch.link_enabled   <= (st_r.mode == M_RX) || (st_r.mode == M_PRE_TX) ||
                               (st_r.mode == M_TX);
      out_ch.charge_led     <= st_r.led;
      out_ch.link_out_valid <= st_r.link_v;
      out_ch.link_out_byte  <= link_b;
      out_ch.host_out_valid <= st_r.host_v;
      out_ch.host_out_byte  <= host_b;
      out_ch.sync_time      <= st_r.sync;
    end
  end

  assign out_ch.valid = out_v_r;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for charge_comm_time_slot_sequencer_top: mode timing, relays, FIFOs.
// A clocked driver and monitor run against an in-bench predictor of the sequencer.
// Depends on ccts_pkg, the ccts interfaces and the sequencer RTL.
module tb;
  import ccts_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int HOLD_CYCLES = 300;
  localparam int PRINT_CAP   = 40;
  localparam cfg_idx_t CFG_UNUSED = 3'd7;

  typedef struct packed {
    op_t   op;
    byte_t data;
    logic  line_low;
  } slot_item_t;

  typedef struct packed {
    mode_t mode;
    logic  relay_tx;
    logic  relay_rx;
    logic  relay_charge;
    logic  link_enabled;
    logic  charge_led;
    logic  link_v;
    byte_t link_b;
    logic  host_v;
    byte_t host_b;
    time_t sync;
  } status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ccts_in_if  in_bus ();
  ccts_out_if out_bus ();
  ccts_cfg_if cfg_bus ();

  charge_comm_time_slot_sequencer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  time_t slot_limits [NUM_CFG] = CFG_RESET;
  mode_t cur_mode = M_CHG;
  time_t elapsed = '0;
  time_t sync_rec = '0;
  byte_t tx_mem [TX_DEPTH];
  byte_t rx_mem [RX_DEPTH];
  int    tx_rd = 0, tx_cnt = 0, rx_rd = 0, rx_cnt = 0;
  logic  send_pend = 1'b0, rx_seen = 1'b0, led = 1'b0;

  slot_item_t pending_items [$];
  status_t    due_status [$];
  slot_item_t next_item;
  status_t    seen;

  int   cycles = 0, errors = 0, queued = 0, accepted = 0, results = 0, settings = 0;
  int   link_bytes = 0, host_bytes = 0, tx_drops = 0, rx_drops = 0;
  int   in_gap = 0, out_gap = 0;
  logic in_took = 1'b0;
  logic quiet = 1'b0;
  logic hold_go = 1'b0;
  logic hold_on = 1'b0;

  function automatic void switch_mode(mode_t m);
    cur_mode = m;
    elapsed = '0;
  endfunction

  function automatic status_t step_time_slot(slot_item_t it);
    status_t r;
    r = '0;
    if (it.op == OP_TICK && elapsed != '1) elapsed++;
    if (it.op == OP_HOST) begin
      if (tx_cnt < TX_DEPTH) begin
        tx_mem[(tx_rd + tx_cnt) % TX_DEPTH] = it.data;
        tx_cnt++;
      end else begin
        tx_drops++;
      end
    end
    case (cur_mode)
      M_CHG: begin
        if (elapsed > slot_limits[CFG_CHARGE_TIME]) begin
          switch_mode(M_PRE_RX);
        end else if (rx_seen && rx_cnt > 0) begin
          r.host_v = 1'b1;
          r.host_b = rx_mem[rx_rd];
          rx_rd = (rx_rd + 1) % RX_DEPTH;
          rx_cnt--;
        end
      end
      M_PRE_RX: begin
        sync_rec = elapsed;
        if (sync_rec > slot_limits[CFG_SYNC_TIMEOUT]) switch_mode(M_RST);
        else if (it.op == OP_TICK && it.line_low) switch_mode(M_RX);
      end
      M_RX: begin
        if ({1'b0, elapsed} + {1'b0, sync_rec} > {1'b0, slot_limits[CFG_RECEIVE_TIME]}) begin
          switch_mode(M_PRE_TX);
        end else if (it.op == OP_LINK) begin
          led = 1'b1;
          if (rx_cnt < RX_DEPTH) begin
            rx_mem[(rx_rd + rx_cnt) % RX_DEPTH] = it.data;
            rx_cnt++;
            rx_seen = 1'b1;
          end else begin
            rx_drops++;
          end
        end
      end
      M_PRE_TX: begin
        if (elapsed > slot_limits[CFG_RX_TO_TX]) begin
          switch_mode(M_TX);
          send_pend = 1'b1;
        end
      end
      M_TX: begin
        if (elapsed > slot_limits[CFG_TRANSMIT_TIME]) begin
          switch_mode(M_POST_TX);
        end else if (send_pend) begin
          if (tx_cnt > 0) begin
            r.link_v = 1'b1;
            r.link_b = tx_mem[tx_rd];
            tx_rd = (tx_rd + 1) % TX_DEPTH;
            tx_cnt--;
          end
          if (tx_cnt == 0) send_pend = 1'b0;
        end
      end
      M_POST_TX: if (elapsed > slot_limits[CFG_TX_TO_CHARGE]) switch_mode(M_CHG);
      M_RST:     if (elapsed > slot_limits[CFG_RST_TO_CHARGE]) switch_mode(M_CHG);
      default: ;
    endcase
    r.mode         = cur_mode;
    r.relay_tx     = (cur_mode == M_PRE_TX || cur_mode == M_TX);
    r.relay_rx     = (cur_mode == M_PRE_RX || cur_mode == M_RX);
    r.relay_charge = (cur_mode == M_CHG);
    r.link_enabled = (cur_mode == M_RX || cur_mode == M_PRE_TX || cur_mode == M_TX);
    r.charge_led   = led;
    r.sync         = sync_rec;
    return r;
  endfunction

  task automatic report(string what);
    errors++;
    if (errors <= PRINT_CAP) $display("tb: MISMATCH cycle %0d: %s", cycles, what);
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report($sformatf("result %0d %s got %0h want %0h", results, name, got, want));
  endtask

  task automatic check_status(status_t got, status_t want);
    compare_field("mode", got.mode, want.mode);
    compare_field("relay_tx", got.relay_tx, want.relay_tx);
    compare_field("relay_rx", got.relay_rx, want.relay_rx);
    compare_field("relay_charge", got.relay_charge, want.relay_charge);
    compare_field("link_enabled", got.link_enabled, want.link_enabled);
    compare_field("charge_led", got.charge_led, want.charge_led);
    compare_field("link_out_valid", got.link_v, want.link_v);
    compare_field("link_out_byte", got.link_b, want.link_b);
    compare_field("host_out_valid", got.host_v, want.host_v);
    compare_field("host_out_byte", got.host_b, want.host_b);
    compare_field("sync_time", got.sync, want.sync);
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_item(op_t op, byte_t data, logic low);
    pending_items.push_back('{op, data, low});
    queued++;
  endfunction

  function automatic void add_random_item();
    int r;
    op_t op;
    r = $urandom_range(0, 99);
    if (r < 40)      op = OP_TICK;
    else if (r < 65) op = OP_HOST;
    else if (r < 88) op = OP_LINK;
    else             op = OP_IDLE;
    add_item(op, byte_t'($urandom), logic'($urandom_range(0, 1)));
  endfunction

  task automatic wait_drained();
    while (accepted != queued || due_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, time_t val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    if (idx < NUM_CFG) slot_limits[idx] = val;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic apply_setting(time_t s [NUM_CFG]);
    int r;
    for (r = 0; r < NUM_CFG; r++) write_reg(cfg_idx_t'(r), s[r]);
    settings++;
  endtask

  task automatic walk_to(mode_t target, logic low);
    int tries;
    tries = 0;
    while (cur_mode != target && tries < 16) begin
      add_item(OP_TICK, byte_t'($urandom), low);
      wait_drained();
      tries++;
    end
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst_n && !(in_bus.valid && !in_took)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_bus.valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        next_item = pending_items.pop_front();
        in_bus.valid     <= 1'b1;
        in_bus.op        <= next_item.op;
        in_bus.data_byte <= next_item.data;
        in_bus.line_low  <= next_item.line_low;
        in_gap = pick_gap();
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // result sink stalls
  always @(negedge clk) begin
    if (hold_on || out_gap > 0) begin
      out_bus.ready <= 1'b0;
      if (out_gap > 0) out_gap--;
    end else begin
      out_bus.ready <= 1'b1;
      out_gap = pick_gap();
    end
  end

  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on = 1'b0;
  end

  // monitor: predict on each input transfer, check each result transfer
  always @(posedge clk) begin
    in_took = rst_n && in_bus.valid && in_bus.ready;
    if (in_took) begin
      due_status.push_back(step_time_slot('{in_bus.op, in_bus.data_byte, in_bus.line_low}));
      accepted++;
    end
    if (rst_n && out_bus.valid && out_bus.ready) begin
      seen = '{mode: out_bus.mode, relay_tx: out_bus.relay_tx, relay_rx: out_bus.relay_rx,
               relay_charge: out_bus.relay_charge, link_enabled: out_bus.link_enabled,
               charge_led: out_bus.charge_led, link_v: out_bus.link_out_valid,
               link_b: out_bus.link_out_byte, host_v: out_bus.host_out_valid,
               host_b: out_bus.host_out_byte, sync: out_bus.sync_time};
      if (seen.link_v === 1'b1) link_bytes++;
      if (seen.host_v === 1'b1) host_bytes++;
      if (due_status.size() == 0) report("result transfer with nothing awaited");
      else check_status(seen, due_status.pop_front());
      results++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    time_t s [NUM_CFG];
    int ph, r, n;
    in_bus.valid     = 1'b0;
    in_bus.op        = OP_IDLE;
    in_bus.data_byte = '0;
    in_bus.line_low  = 1'b0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = CFG_CHARGE_TIME;
    cfg_bus.data     = '0;
    out_bus.ready    = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // defaults after reset; link byte outside receive, data ignored on a tick
    add_item(OP_IDLE, 8'h00, 1'b1);
    add_item(OP_HOST, 8'hFF, 1'b0);
    add_item(OP_LINK, 8'hA5, 1'b1);
    add_item(OP_TICK, 8'h3C, 1'b1);
    wait_drained();
    write_reg(CFG_UNUSED, 16'hFFFF);
    s = '{16'd0, 16'd2, 16'd3, 16'd0, 16'd3, 16'd0, 16'd0};
    apply_setting(s);

    // one full slot cycle, then the sync-timeout path
    add_item(OP_TICK, 8'h00, 1'b0);
    add_item(OP_TICK, 8'h00, 1'b0);
    add_item(OP_IDLE, 8'h00, 1'b1);
    add_item(OP_TICK, 8'h00, 1'b1);
    add_item(OP_LINK, 8'hFF, 1'b0);
    add_item(OP_LINK, 8'h00, 1'b0);
    add_item(OP_HOST, 8'h5A, 1'b0);
    repeat (3) add_item(OP_TICK, 8'h00, 1'b0);
    repeat (3) add_item(OP_IDLE, 8'h00, 1'b0);
    add_item(OP_HOST, 8'h33, 1'b1);
    repeat (5) add_item(OP_TICK, 8'h00, 1'b0);
    add_item(OP_IDLE, 8'h00, 1'b0);
    add_item(OP_IDLE, 8'h00, 1'b0);
    repeat (5) add_item(OP_TICK, 8'h00, 1'b0);
    wait_drained();

    // random traffic over several limit settings
    for (ph = 0; ph < 8; ph++) begin
      for (r = 0; r < NUM_CFG; r++) begin
        case (ph)
          0:       s[r] = '0;
          1:       s[r] = '1;
          2:       s[r] = $urandom_range(0, 1) ? 16'hFFFF : time_t'($urandom_range(0, 2));
          default: s[r] = time_t'($urandom_range(0, 6));
        endcase
      end
      apply_setting(s);
      quiet = ($urandom_range(0, 3) == 0);
      for (n = 0; n < 28; n++) add_random_item();
      if (ph == 4) begin
        quiet = 1'b0;
        hold_go = 1'b1;
      end
      wait_drained();
    end

    // transmit FIFO past full in receive, drain it to the link, then receive bytes to host
    quiet = 1'b1;
    s = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0};
    apply_setting(s);
    walk_to(M_RX, 1'b1);
    repeat (TX_DEPTH + 8) add_item(OP_HOST, byte_t'($urandom), logic'($urandom_range(0, 1)));
    repeat (8) add_item(OP_LINK, byte_t'($urandom), logic'($urandom_range(0, 1)));
    wait_drained();
    write_reg(CFG_RECEIVE_TIME, 16'd0);
    write_reg(CFG_TRANSMIT_TIME, 16'hFFFF);
    walk_to(M_TX, 1'b0);
    repeat (TX_DEPTH + 4) add_item(OP_IDLE, byte_t'($urandom), 1'b0);
    wait_drained();
    write_reg(CFG_TRANSMIT_TIME, 16'd0);
    walk_to(M_CHG, 1'b0);
    repeat (16) add_item(OP_IDLE, byte_t'($urandom), 1'b1);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("tb: %0d items in, %0d results checked, %0d limit settings, long sink hold",
             accepted, results, settings);
    $display("tb: %0d bytes to link, %0d to host; %0d host and %0d link bytes dropped",
             link_bytes, host_bytes, tx_drops, rx_drops);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
